### design/lcgdw_pkg.sv
// Shared types, constants and helper functions for the LCG draw-without-replacement block.
// Depends on nothing; lcgdw_mac, lcgdw_mod and lcg_draw_without_replacement import it.
package lcgdw_pkg;

	// Field and storage widths.
	localparam int BASE_W   = 16;
	localparam int CNT_W    = 9;
	localparam int VAL_W    = 17;
	localparam int POS_W    = 10;
	localparam int FUNC_W   = 2;
	localparam int SEED_W   = 32;
	localparam int OP_W     = 18;
	localparam int DRAW_W   = 15;
	localparam int DRAW_LSB = 16;
	localparam int STEP_W   = 5;

	// The pool bitmap is kept in memory words of this many entries.
	localparam int WORD_W  = 16;
	localparam int WORD_BW = 4;

	localparam int DEF_POOL_SIZE = 256;

	// Generator and coordinate hash constants.
	localparam logic [SEED_W-1:0] LCG_MUL   = 32'd214013;
	localparam logic [SEED_W-1:0] LCG_ADD   = 32'd2531011;
	localparam logic [SEED_W-1:0] HASH_X    = 32'd110291;
	localparam logic [SEED_W-1:0] HASH_Y    = 32'd167801;
	localparam logic [SEED_W-1:0] HASH_C    = 32'd81569;
	localparam logic [DRAW_W-1:0] DRAW_MASK = 15'h7FFF;

	// Serial step counts: multiplier bits of each product, dividend bits of the modulo.
	localparam int LCG_STEPS  = 18;
	localparam int HASH_STEPS = POS_W;
	localparam int MOD_STEPS  = DRAW_W;

	// Input function codes.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_REFILL = 2'd0,
		FUNC_DRAW   = 2'd1,
		FUNC_RESEED = 2'd2
	} func_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_RANGE_BASE  = 1'b0,
		REG_RANGE_COUNT = 1'b1
	} reg_idx_t;

	// Control of the serial multiply-accumulate unit.
	typedef struct packed {
		logic load_acc;
		logic load_op;
		logic step;
	} mac_ctrl_t;

	// Control of the serial modulo unit.
	typedef struct packed {
		logic start;
		logic step;
	} mod_ctrl_t;

	// Number of free entries in one bitmap word.
	function automatic logic [WORD_BW:0] popcount(input logic [WORD_W-1:0] word);
		logic [WORD_BW:0] sum;
		sum = '0;
		for (int b = 0; b < WORD_W; b++) begin
			sum = sum + (WORD_BW+1)'(word[b]);
		end
		return sum;
	endfunction

endpackage

### design/lcgdw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lcgdw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/lcgdw_mac.sv
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle while ctrl.step is high, acc += op[0] ? addend : 0.
// Depends on lcgdw_pkg.
module lcgdw_mac import lcgdw_pkg::*; (
	input  logic              clk,
	input  mac_ctrl_t         ctrl,
	input  logic [SEED_W-1:0] acc_init,
	input  logic [OP_W-1:0]   op_init,
	input  logic [SEED_W-1:0] add_init,
	output logic [SEED_W-1:0] acc
);

	logic [SEED_W-1:0] acc_q;
	logic [OP_W-1:0]   op_q;
	logic [SEED_W-1:0] add_q;

	// The accumulator takes the partial product of the current multiplier bit.
	always_ff @(posedge clk) begin
		if (ctrl.load_acc) begin
			acc_q <= acc_init;
		end else if (ctrl.step && op_q[0]) begin
			acc_q <= acc_q + add_q;
		end
	end

	// Multiplier shifts right and the addend shifts left, one bit a step.
	always_ff @(posedge clk) begin
		if (ctrl.load_op || ctrl.load_acc) begin
			op_q  <= op_init;
			add_q <= add_init;
		end else if (ctrl.step) begin
			op_q  <= op_q >> 1;
			add_q <= add_q << 1;
		end
	end

	assign acc = acc_q;

endmodule

### design/lcgdw_mod.sv
// Bit-serial restoring modulo: one dividend bit per cycle while ctrl.step is high, against a pool-count divisor.
// Depends on lcgdw_pkg.
module lcgdw_mod import lcgdw_pkg::*; (
	input  logic              clk,
	input  mod_ctrl_t         ctrl,
	input  logic [DRAW_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic [CNT_W-1:0]  rem
);

	logic [DRAW_W-1:0] div_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W:0]    trial;

	// Bring down the next dividend bit; subtract when the divisor fits.
	assign trial = {rem_q[CNT_W-1:0], div_q[DRAW_W-1]};

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			div_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (ctrl.step) begin
			div_q <= div_q << 1;
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign rem = rem_q[CNT_W-1:0];

endmodule

### design/lcg_draw_without_replacement.sv
// Draws values from a configured range without repeats, driven by a 32-bit LCG.
// Depends on lcgdw_pkg, lcgdw_ram, lcgdw_mac and lcgdw_mod.
//
// Usage: items arrive on in_valid/in_ready with func, pos_x and pos_y. A refill (func 0)
// marks the first min(range_count, POOL_SIZE) entries of the pool free; a reseed
// (func 2) loads the seed from a hash of pos_x and pos_y; a draw (func 1) returns one
// result on out_valid/out_ready. Code 3 is taken and ignored. Refill and reseed produce
// no result transfer. range_base and range_count are set on the cfg_we/cfg_addr/cfg_wdata
// port; the user must write them only while idle, as the block does not enforce it.
// One item is processed at a time; in_ready is high only between items.
// Reseed runs two 10-bit serial products and then a seed write.
// Refill writes ceil(POOL_SIZE/16) bitmap words, one 16-entry word per cycle.
// A draw from a pool with two or more entries runs an 18-bit serial generator product
// and a 15-bit serial modulo, then checks bitmap words at one per cycle up to the one
// that holds the entry and steps past B bits inside it (B <= 15).
// A draw from a pool with one entry skips the product and modulo; an empty pool answers
// exhausted without a scan. The result sits in an output register: when the receiver
// stalls, the next item is still taken, and only a later draw waits for that register
// to free up.
// Reset empties the pool, zeroes the seed and sets range_base 0 and range_count 256;
// no clearing pass is needed since an empty pool never reads the bitmap memory.
module lcg_draw_without_replacement import lcgdw_pkg::*; #(
	parameter int POOL_SIZE = DEF_POOL_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [POS_W-1:0]  pos_x,
	input  logic [POS_W-1:0]  pos_y,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VAL_W-1:0]  drawn_value,
	output logic              exhausted,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [BASE_W-1:0] cfg_wdata
);

	localparam int NWORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IW     = AW + WORD_BW;
	localparam int CW     = (IW > CNT_W) ? IW + 1 : CNT_W + 1;
	localparam logic [AW-1:0]    LAST_WORD = AW'(NWORDS - 1);
	localparam logic [CNT_W-1:0] POOL_CAP  = (POOL_SIZE > 511) ? '1 : CNT_W'(POOL_SIZE);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_HASH_X   = 12'b0000_0000_0010,
		ST_HASH_Y   = 12'b0000_0000_0100,
		ST_LCG      = 12'b0000_0000_1000,
		ST_SEED     = 12'b0000_0001_0000,
		ST_MOD      = 12'b0000_0010_0000,
		ST_SCAN_RD  = 12'b0000_0100_0000,
		ST_SCAN_CHK = 12'b0000_1000_0000,
		ST_BIT      = 12'b0001_0000_0000,
		ST_WRITE    = 12'b0010_0000_0000,
		ST_RESULT   = 12'b0100_0000_0000,
		ST_FILL     = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [STEP_W-1:0] step_q;
	logic              draw_q;
	logic [SEED_W-1:0] seed_q;
	logic [CNT_W-1:0]  remaining_q;
	logic [CNT_W-1:0]  fill_n_q;
	logic [CNT_W-1:0]  n_q;
	logic [AW-1:0]     waddr_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] sh_q;
	logic [WORD_W-1:0] mask_q;
	logic [WORD_BW-1:0] bit_q;
	logic              res_exh_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  drawn_q;
	logic              exh_q;
	logic [BASE_W-1:0] range_base_q;
	logic [CNT_W-1:0]  range_count_q;
	logic [POS_W-1:0]  pos_y_q;

	mac_ctrl_t         mac_ctrl;
	logic [SEED_W-1:0] mac_acc_init;
	logic [OP_W-1:0]   mac_op_init;
	logic [SEED_W-1:0] mac_add_init;
	logic [SEED_W-1:0] mac_acc;

	mod_ctrl_t         mod_ctrl;
	logic [CNT_W-1:0]  mod_rem;

	logic              ram_we;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic              accept;
	logic              out_free;
	logic [CNT_W-1:0]  fill_n;
	logic [WORD_W-1:0] fill_mask;
	logic [WORD_BW:0]  pop;
	logic              word_hit;
	logic              bit_hit;
	logic              step_last;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// A refill never marks more entries than the pool holds.
	assign fill_n = (32'(range_count_q) > 32'(POOL_SIZE)) ? POOL_CAP : range_count_q;

	// Free-entry mask for the bitmap word currently being filled.
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			fill_mask[b] = CW'({waddr_q, WORD_BW'(b)}) < CW'(fill_n_q);
		end
	end

	// Scan decisions: does the wanted entry lie in this word, is it this bit.
	assign pop      = popcount(ram_rdata);
	assign word_hit = n_q < CNT_W'(pop);
	assign bit_hit  = sh_q[0] && (n_q == '0);

	// Last step of the current serial operation.
	always_comb begin
		unique case (state_q)
			ST_HASH_X, ST_HASH_Y: step_last = (step_q == STEP_W'(HASH_STEPS - 1));
			ST_LCG:               step_last = (step_q == STEP_W'(LCG_STEPS - 1));
			ST_MOD:               step_last = (step_q == STEP_W'(MOD_STEPS - 1));
			default:              step_last = 1'b0;
		endcase
	end

	// Next state and control of the serial units and the bitmap memory.
	always_comb begin
		state_d      = state_q;
		mac_ctrl     = '0;
		mac_acc_init = '0;
		mac_op_init  = '0;
		mac_add_init = '0;
		mod_ctrl     = '0;
		ram_we       = 1'b0;
		ram_wdata    = fill_mask;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_REFILL: state_d = ST_FILL;
						FUNC_RESEED: begin
							mac_ctrl.load_acc = 1'b1;
							mac_acc_init      = HASH_C;
							mac_op_init       = OP_W'(pos_x);
							mac_add_init      = HASH_X;
							state_d           = ST_HASH_X;
						end
						FUNC_DRAW: begin
							if (remaining_q == '0) begin
								state_d = ST_RESULT;
							end else if (remaining_q == CNT_W'(1)) begin
								state_d = ST_SCAN_RD;
							end else begin
								mac_ctrl.load_acc = 1'b1;
								mac_acc_init      = LCG_ADD;
								mac_op_init       = OP_W'(LCG_MUL);
								mac_add_init      = seed_q;
								state_d           = ST_LCG;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_HASH_X: begin
				mac_ctrl.step = 1'b1;
				if (step_last) begin
					mac_ctrl.load_op = 1'b1;
					mac_op_init      = OP_W'(pos_y_q);
					mac_add_init     = HASH_Y;
					state_d          = ST_HASH_Y;
				end
			end
			ST_HASH_Y: begin
				mac_ctrl.step = 1'b1;
				if (step_last) begin
					state_d = ST_SEED;
				end
			end
			ST_LCG: begin
				mac_ctrl.step = 1'b1;
				if (step_last) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				if (draw_q) begin
					mod_ctrl.start = 1'b1;
					state_d        = ST_MOD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MOD: begin
				mod_ctrl.step = 1'b1;
				if (step_last) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (word_hit) begin
					state_d = ST_BIT;
				end
			end
			ST_BIT: begin
				if (bit_hit) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = word_q & ~mask_q;
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				ram_we = 1'b1;
				if (waddr_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The speculative read of the following word keeps the scan at one word per cycle.
	assign ram_raddr = (state_q == ST_SCAN_CHK) ? AW'(waddr_q + 1'b1) : waddr_q;

	// The y coordinate is held from the accepted transfer for the second hash product.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_y_q <= pos_y;
		end
	end

	// State register and step counter, which restarts on every state change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_base_q  <= '0;
			range_count_q <= CNT_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RANGE_BASE:  range_base_q  <= cfg_wdata;
				REG_RANGE_COUNT: range_count_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Generator seed and free-entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			remaining_q <= '0;
		end else begin
			if (state_q == ST_SEED) begin
				seed_q <= mac_acc;
			end
			if (accept && (func == FUNC_REFILL)) begin
				remaining_q <= fill_n;
			end else if (state_q == ST_WRITE) begin
				remaining_q <= remaining_q - 1'b1;
			end
		end
	end

	// Pool scan and refill datapath: word address, rank of the wanted entry, bit stepping.
	always_ff @(posedge clk) begin
		if (accept) begin
			draw_q    <= (func == FUNC_DRAW);
			res_exh_q <= (remaining_q == '0);
			fill_n_q  <= fill_n;
			waddr_q   <= '0;
		end
		unique case (state_q)
			ST_SCAN_RD: begin
				n_q <= (remaining_q == CNT_W'(1)) ? '0 : mod_rem;
			end
			ST_SCAN_CHK: begin
				if (word_hit) begin
					word_q <= ram_rdata;
					sh_q   <= ram_rdata;
					mask_q <= WORD_W'(1);
					bit_q  <= '0;
				end else begin
					n_q     <= n_q - CNT_W'(pop);
					waddr_q <= AW'(waddr_q + 1'b1);
				end
			end
			ST_BIT: begin
				if (!bit_hit) begin
					if (sh_q[0]) begin
						n_q <= n_q - 1'b1;
					end
					sh_q   <= sh_q >> 1;
					mask_q <= mask_q << 1;
					bit_q  <= bit_q + 1'b1;
				end
			end
			ST_FILL: begin
				waddr_q <= AW'(waddr_q + 1'b1);
			end
			default: ;
		endcase
	end

	// Output register: a draw result waits here until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			exh_q <= res_exh_q;
			if (res_exh_q) begin
				drawn_q <= '0;
			end else begin
				drawn_q <= VAL_W'(range_base_q) + VAL_W'({waddr_q, bit_q});
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign drawn_value = drawn_q;
	assign exhausted   = exh_q;

	// Serial generator and hash products.
	lcgdw_mac u_mac (
		.clk      (clk),
		.ctrl     (mac_ctrl),
		.acc_init (mac_acc_init),
		.op_init  (mac_op_init),
		.add_init (mac_add_init),
		.acc      (mac_acc)
	);

	// Serial modulo of the draw bits by the free-entry count.
	lcgdw_mod u_mod (
		.clk      (clk),
		.ctrl     (mod_ctrl),
		.dividend (DRAW_W'(mac_acc >> DRAW_LSB) & DRAW_MASK),
		.divisor  (remaining_q),
		.rem      (mod_rem)
	);

	// Pool bitmap, one word of entries per address.
	lcgdw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NWORDS),
		.AW    (AW)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
